// ===== sv/ggt_pkg.sv =====
// ----------------------------------------------------------------------------
// ggt_pkg
// Types, constants and the level table of the gray gamma tint pixel unit.
// ----------------------------------------------------------------------------
package ggt_pkg;

    typedef struct packed {
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } t_pix_out;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED   = 8'd3;

    localparam logic [CFG_DATA_W-1:0] RST_GAMMA      = 16'd5734;
    localparam logic [CFG_DATA_W-1:0] RST_TINT_BLUE  = 16'd24576;
    localparam logic [CFG_DATA_W-1:0] RST_TINT_GREEN = 16'd0;
    localparam logic [CFG_DATA_W-1:0] RST_TINT_RED   = 16'd0;

    // datapath widths
    localparam int unsigned LUMA_W = 24;  // Q8.16 luma
    localparam int unsigned MSB_W  = 5;   // bit position of the luma msb
    localparam int unsigned MANT_W = 31;  // Q1.30 mantissa
    localparam int unsigned FRAC_W = 16;  // log2 fraction bits
    localparam int unsigned LG_W   = MSB_W + FRAC_W;  // signed Q16 log2
    localparam int unsigned Q_W    = 25;  // power in Q16, signed
    localparam int unsigned TAB_W  = 19;  // log2 of integer levels, Q16
    localparam int unsigned N_SQ   = 16;  // squaring steps
    localparam int unsigned N_SRCH = 8;   // binary search steps

    // Q16 luma weights
    localparam logic [LUMA_W-1:0] W_RED   = 24'd19661;
    localparam logic [LUMA_W-1:0] W_GREEN = 24'd38666;
    localparam logic [LUMA_W-1:0] W_BLUE  = 24'd7209;

    typedef logic [TAB_W-1:0] t_lg_tab [256];

    // log2 of the Q16 value r << 16, same squaring method as the datapath
    function automatic logic [TAB_W-1:0] f_lg_level(input int unsigned r);
        logic [63:0] x;
        logic [63:0] m;
        logic [15:0] frac;
        int          e;
        x = 64'(r) << 16;
        e = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                e = i;
            end
        end
        m    = x << (30 - e);
        frac = '0;
        for (int k = 0; k < 16; k++) begin
            m    = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return {3'(e - 16), frac};
    endfunction

    function automatic t_lg_tab f_build_lg_tab();
        t_lg_tab tab;
        for (int r = 0; r < 256; r++) begin
            tab[r] = (r == 0) ? '0 : f_lg_level(r);
        end
        return tab;
    endfunction

    localparam t_lg_tab LG_TAB = f_build_lg_tab();

endpackage

// ===== sv/gray_gamma_tint_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// gray_gamma_tint_pixel_unit
// BGR pixel to tinted gray: luma, power-law gamma via log2, per-channel tint.
//
//   channel  direction  signals                          payload
//   pixel    in         i_valid / o_ready                i_pixel  (t_pix_in)
//   pixel    out        o_valid / i_ready                o_pixel  (t_pix_out)
//   config   in         i_cfg_we, i_cfg_idx              i_cfg_wdata
//
// Takes one pixel per clock while o_ready is high.
// The path is luma, msb search, normalize, the 16 mantissa squaring stages of
// log2, exponent multiply, 8 search stages and the output register.
// Reset loads the register defaults and empties the pipeline.
// A stalled output parks one result in a skid register; o_ready drops only
// while that register is full, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
module gray_gamma_tint_pixel_unit
    import ggt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_pix_in               i_pixel,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_pix_out              o_pixel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned S_NORM = 2;
    localparam int unsigned S_POW  = S_NORM + N_SQ + 1;
    localparam int unsigned NV     = S_POW + N_SRCH + 1;

    logic [CFG_DATA_W-1:0] r_gamma;
    logic [CFG_DATA_W-1:0] r_tint_blue;
    logic [CFG_DATA_W-1:0] r_tint_green;
    logic [CFG_DATA_W-1:0] r_tint_red;

    logic          en;
    logic [NV-1:0] r_vld;

    logic [LUMA_W-1:0] r_luma;
    logic [LUMA_W-1:0] r_luma_b;
    logic [MSB_W-1:0]  n_msb;
    logic [MSB_W-1:0]  r_msb;

    logic [MANT_W-1:0] r_mant [N_SQ+1];
    logic [MSB_W-1:0]  r_exp  [N_SQ+1];
    logic [FRAC_W-1:0] r_frac [N_SQ+1];

    logic signed [LG_W-1:0]         w_lg;
    logic signed [LG_W+CFG_DATA_W:0] w_pow;

    logic [7:0]            r_lvl [N_SRCH+1];
    logic signed [Q_W-1:0] r_q   [N_SRCH];

    t_pix_out w_res;
    logic     r_out_vld;
    logic     r_skid_vld;
    t_pix_out r_out;
    t_pix_out r_skid;

    // ------------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma      <= RST_GAMMA;
            r_tint_blue  <= RST_TINT_BLUE;
            r_tint_green <= RST_TINT_GREEN;
            r_tint_red   <= RST_TINT_RED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAMMA:      r_gamma      <= i_cfg_wdata;
                CFG_TINT_BLUE:  r_tint_blue  <= i_cfg_wdata;
                CFG_TINT_GREEN: r_tint_green <= i_cfg_wdata;
                CFG_TINT_RED:   r_tint_red   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pipeline control: every stage advances unless the skid register is full
    assign en      = !r_skid_vld;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------------
    // luma, msb position, normalize
    always_comb begin
        n_msb = '0;
        for (int i = 0; i < LUMA_W; i++) begin
            if (r_luma[i]) begin
                n_msb = MSB_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_luma    <= W_RED * LUMA_W'(i_pixel.in_red)
                       + W_GREEN * LUMA_W'(i_pixel.in_green)
                       + W_BLUE * LUMA_W'(i_pixel.in_blue);
            r_luma_b  <= r_luma;
            r_msb     <= n_msb;
            // zero luma normalizes to a zero mantissa and log2 of -16
            r_mant[0] <= MANT_W'({{(MANT_W-LUMA_W){1'b0}}, r_luma_b}
                                 << (MSB_W'(MANT_W - 1) - r_msb));
            r_exp[0]  <= r_msb;
            r_frac[0] <= '0;
        end
    end

    // ------------------------------------------------------------------------
    // log2 fraction: square the mantissa, emit one bit per stage
    for (genvar k = 0; k < N_SQ; k++) begin : g_sq
        logic [2*MANT_W-1:0] w_prod;
        logic [MANT_W:0]     w_sq;

        assign w_prod = r_mant[k] * r_mant[k];
        assign w_sq   = w_prod[2*MANT_W-1:MANT_W-1];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mant[k+1] <= w_sq[MANT_W] ? w_sq[MANT_W:1] : w_sq[MANT_W-1:0];
                r_frac[k+1] <= {r_frac[k][FRAC_W-2:0], w_sq[MANT_W]};
                r_exp[k+1]  <= r_exp[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // power in log domain, kept as floor(lg * gamma / 4096)
    assign w_lg  = $signed({MSB_W'(r_exp[N_SQ] - MSB_W'(16)), r_frac[N_SQ]});
    assign w_pow = w_lg * $signed({1'b0, r_gamma});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q[0]   <= w_pow[Q_W+11:12];
            r_lvl[0] <= '0;
        end
    end

    // ------------------------------------------------------------------------
    // binary search for the largest level whose log2 stays at or below the power
    for (genvar j = 0; j < N_SRCH; j++) begin : g_srch
        localparam logic [7:0] BIT = 8'(1) << (N_SRCH - 1 - j);
        logic [7:0] w_cand;
        logic       w_fit;

        assign w_cand = r_lvl[j] | BIT;
        assign w_fit  = $signed({{(Q_W-TAB_W){1'b0}}, LG_TAB[w_cand]}) <= r_q[j];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lvl[j+1] <= w_fit ? w_cand : r_lvl[j];
            end
        end

        if (j < N_SRCH - 1) begin : g_q
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_q[j+1] <= r_q[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tint toward white, saturate
    function automatic logic [7:0] f_tint(input logic [7:0] y,
                                          input logic [CFG_DATA_W-1:0] t);
        logic [23:0] prod;
        logic [9:0]  sum;
        prod = 24'(8'd255 - y) * 24'(t);
        sum  = 10'(y) + 10'(prod[23:15]);
        return (sum > 10'd255) ? 8'hFF : sum[7:0];
    endfunction

    always_comb begin
        w_res.out_blue  = f_tint(r_lvl[N_SRCH], r_tint_blue);
        w_res.out_green = f_tint(r_lvl[N_SRCH], r_tint_green);
        w_res.out_red   = f_tint(r_lvl[N_SRCH], r_tint_red);
    end

    // ------------------------------------------------------------------------
    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_vld[NV-1];
            end
        end else if (r_vld[NV-1] && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end else if (!r_skid_vld) begin
            r_skid <= w_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_pixel = r_out;

`ifndef SYNTHESIS
    // a parked result always has a result ahead of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held with empty output register");

    // a stall freezes the stage valids
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    // an input transfer enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted pixel missing from first stage");
`endif

endmodule
